// ===== rtl/kps_pkg.sv =====
// ============================================================================
// kps_pkg
// Shared types, constants and key map for the 4x4 matrix keypad scanner.
// ============================================================================
package kps_pkg;

    localparam int ROW_COUNT    = 4;
    localparam int COLUMN_COUNT = 4;
    localparam int ROW_W        = $clog2(ROW_COUNT);
    localparam int COL_W        = $clog2(COLUMN_COUNT);

    localparam int TIMEOUT_W  = 24;
    localparam int DEBOUNCE_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_PASSES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_SELECT  = 2'd2;

    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 24'd75000;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;

    localparam logic [ROW_COUNT-1:0] ROWS_IDLE = 4'hF;
    localparam logic [7:0] CHAR_TIMEOUT = 8'h23;

    typedef struct packed {
        logic [TIMEOUT_W-1:0]  timeout_passes;
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic                  layout_select;
    } cfg_t;

    typedef struct packed {
        logic [ROW_COUNT-1:0] row_drive;
        logic                 busy_res;
        logic                 done_res;
        logic [7:0]           key_char;
        logic                 timed_out;
    } res_t;

    function automatic logic [7:0] key_lookup(
        input logic             layout,
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        logic [7:0] k;
        k = 8'h00;
        unique case (row)
            2'd0:
            begin
                unique case (col)
                    2'd0: k = layout ? "1" : "7";
                    2'd1: k = layout ? "2" : "8";
                    2'd2: k = layout ? "3" : "9";
                    default: k = "A";
                endcase
            end
            2'd1:
            begin
                unique case (col)
                    2'd0: k = "4";
                    2'd1: k = "5";
                    2'd2: k = "6";
                    default: k = "B";
                endcase
            end
            2'd2:
            begin
                unique case (col)
                    2'd0: k = layout ? "7" : "1";
                    2'd1: k = layout ? "8" : "2";
                    2'd2: k = layout ? "9" : "3";
                    default: k = "C";
                endcase
            end
            default:
            begin
                unique case (col)
                    2'd0: k = "*";
                    2'd1: k = "0";
                    2'd2: k = "=";
                    default: k = "D";
                endcase
            end
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/kps_cfg.sv =====
// ============================================================================
// kps_cfg
// Configuration register file: timeout budget, debounce length, layout.
// ============================================================================
module kps_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kps_pkg::CFG_DATA_W-1:0] cfg_data,
    output kps_pkg::cfg_t                  cfg
);

    kps_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_passes <= kps_pkg::TIMEOUT_RESET;
            cfg_reg.debounce_ticks <= kps_pkg::DEBOUNCE_RESET;
            cfg_reg.layout_select  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                kps_pkg::CFG_TIMEOUT_PASSES:
                    cfg_reg.timeout_passes <= cfg_data[kps_pkg::TIMEOUT_W-1:0];
                kps_pkg::CFG_DEBOUNCE_TICKS:
                    cfg_reg.debounce_ticks <= cfg_data[kps_pkg::DEBOUNCE_W-1:0];
                kps_pkg::CFG_LAYOUT_SELECT:
                    cfg_reg.layout_select <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/kps_step.sv =====
// ============================================================================
// kps_step
// Scan state machine: one transaction per enabled cycle, result formed
// combinationally from the current state and the registered input.
// ============================================================================
module kps_step
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_en,
    input  logic                            mode,
    input  logic [kps_pkg::COLUMN_COUNT-1:0] column_lines,
    input  kps_pkg::cfg_t                   cfg,
    output kps_pkg::res_t                   res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SCAN,
        PH_DEBOUNCE,
        PH_RELEASE
    } phase_t;

    phase_t                          phase_reg,    phase_next;
    logic [kps_pkg::ROW_W-1:0]       row_reg,      row_next;
    logic [kps_pkg::COL_W-1:0]       col_reg,      col_next;
    logic [kps_pkg::TIMEOUT_W-1:0]   passes_reg,   passes_next;
    logic [kps_pkg::DEBOUNCE_W-1:0]  debounce_reg, debounce_next;

    logic [kps_pkg::ROW_COUNT-1:0]   row_pat;
    logic                            hit;
    logic [kps_pkg::COL_W-1:0]       hit_col;
    logic                            col_low;

    assign row_pat = ~(kps_pkg::ROW_COUNT'(1) << row_reg);
    assign col_low = ~column_lines[col_reg];

    always_comb
    begin
        hit     = 1'b0;
        hit_col = '0;
        for (int c = kps_pkg::COLUMN_COUNT - 1; c >= 0; c--)
        begin
            if ((kps_pkg::COL_W'(c) >= col_reg) && !column_lines[c])
            begin
                hit     = 1'b1;
                hit_col = kps_pkg::COL_W'(c);
            end
        end
    end

    always_comb
    begin
        logic go;
        go            = 1'b1;
        phase_next    = phase_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        passes_next   = passes_reg;
        debounce_next = debounce_reg;
        res.row_drive = kps_pkg::ROWS_IDLE;
        res.done_res  = 1'b0;
        res.key_char  = 8'h00;
        res.timed_out = 1'b0;

        if (!mode)
        begin
            phase_next    = PH_SCAN;
            row_next      = '0;
            col_next      = '0;
            passes_next   = cfg.timeout_passes;
            debounce_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_SCAN:
                begin
                    if ((row_reg == '0) && (col_reg == '0))
                    begin
                        if (passes_reg <= kps_pkg::TIMEOUT_W'(1))
                        begin
                            passes_next   = '0;
                            phase_next    = PH_IDLE;
                            res.done_res  = 1'b1;
                            res.key_char  = kps_pkg::CHAR_TIMEOUT;
                            res.timed_out = 1'b1;
                            go            = 1'b0;
                        end
                        else
                        begin
                            passes_next = passes_reg - kps_pkg::TIMEOUT_W'(1);
                        end
                    end
                    if (go)
                    begin
                        res.row_drive = row_pat;
                        if (hit)
                        begin
                            col_next      = hit_col;
                            debounce_next = cfg.debounce_ticks;
                            phase_next    = PH_DEBOUNCE;
                        end
                        else
                        begin
                            col_next = '0;
                            row_next = row_reg + kps_pkg::ROW_W'(1);
                        end
                    end
                end
                PH_DEBOUNCE:
                begin
                    res.row_drive = row_pat;
                    if (debounce_reg != '0)
                    begin
                        debounce_next = debounce_reg - kps_pkg::DEBOUNCE_W'(1);
                    end
                    else if (col_low)
                    begin
                        phase_next = PH_RELEASE;
                    end
                    else
                    begin
                        phase_next = PH_SCAN;
                        col_next   = col_reg + kps_pkg::COL_W'(1);
                        if (col_reg == kps_pkg::COL_W'(kps_pkg::COLUMN_COUNT - 1))
                        begin
                            row_next = row_reg + kps_pkg::ROW_W'(1);
                        end
                    end
                end
                PH_RELEASE:
                begin
                    if (col_low)
                    begin
                        res.row_drive = row_pat;
                    end
                    else
                    begin
                        res.key_char = kps_pkg::key_lookup(cfg.layout_select,
                                                           row_reg, col_reg);
                        res.done_res = 1'b1;
                        phase_next   = PH_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            passes_reg   <= '0;
            debounce_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            passes_reg   <= passes_next;
            debounce_reg <= debounce_next;
        end
    end

endmodule

// ===== rtl/matrix_keypad_scanner_core.sv =====
// ============================================================================
// matrix_keypad_scanner_core
// 4x4 active-low key matrix scanner with debounce, release wait, timeout and
// two selectable key layouts.
// ============================================================================
// One transaction is accepted every cycle unless in_stall is raised, and each
// one yields exactly one result. A transaction passes through an input
// register, then the scan state machine, then the result register. The
// result register lets a new transaction enter while a result is still
// stalled, until the input register is also full. Configuration writes are
// always ready and take effect on the next transaction.
module matrix_keypad_scanner_core
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic [kps_pkg::COLUMN_COUNT-1:0] column_lines,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [kps_pkg::ROW_COUNT-1:0]    row_drive,
    output logic                             busy_res,
    output logic                             done_res,
    output logic [7:0]                       key_char,
    output logic                             timed_out,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kps_pkg::CFG_DATA_W-1:0]   cfg_data
);

    kps_pkg::cfg_t cfg;
    kps_pkg::res_t res;
    kps_pkg::res_t res_reg;

    logic                              in_valid_reg;
    logic                              mode_reg;
    logic [kps_pkg::COLUMN_COUNT-1:0]  cols_reg;
    logic                              out_valid_reg;
    logic                              out_free;
    logic                              step_en;

    assign out_free = !out_valid_reg || !out_stall;
    assign step_en  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    kps_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kps_step u_step
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .mode         (mode_reg),
        .column_lines (cols_reg),
        .cfg          (cfg),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            mode_reg <= mode;
            cols_reg <= column_lines;
        end
        if (step_en)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_drive = res_reg.row_drive;
    assign busy_res  = res_reg.busy_res;
    assign done_res  = res_reg.done_res;
    assign key_char  = res_reg.key_char;
    assign timed_out = res_reg.timed_out;

endmodule
